[src/pmrd_pkg.sv]
package pmrd_pkg;

  localparam int CH_W     = 8;
  localparam int NUM_W    = 17;
  localparam int HUE_W    = 9;
  localparam int BRIGHT_W = 7;
  localparam int CNT_W    = 21;
  localparam int DIV_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_RANGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_DIVISOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_DIVISOR = 2'd2;

  localparam logic [CH_W-1:0]  CHANGE_RANGE_RST = 8'd16;
  localparam logic [DIV_W-1:0] DIVISOR_RST      = 16'd4;

  localparam logic [NUM_W-1:0] DEG_60  = 17'd60;
  localparam logic [NUM_W-1:0] DEG_120 = 17'd120;
  localparam logic [NUM_W-1:0] DEG_240 = 17'd240;
  localparam logic [NUM_W-1:0] DEG_360 = 17'd360;

  localparam logic [HUE_W-1:0]    HUE_RED_MIN    = 9'd340;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RED_MIN = 7'd70;
  localparam logic [14:0]         BRIGHT_SCALE   = 15'd100;

  typedef struct packed {
    logic capture;
    logic upd;
    logic mul;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

[src/pixel_motion_and_red_detect_unit.sv]
// Pixel motion and red detector. Each input transaction carries one pixel of
// the current frame, the matching reference pixel and a last-of-frame mark;
// each yields exactly one result with the HSV hue (0..359) and value
// (0..100), a per-pixel change flag, a red-hit flag and, on the last pixel,
// the frame's motion and colour decisions, after which the frame counters
// clear. One pixel is processed at a time: each accepted pixel passes through
// the 9-step hue divider and then the counter-update, threshold-multiply and
// output-load steps, the last held until the previous result is taken. The
// output register lets a new pixel be accepted while the previous result is
// still waiting to be taken. Configuration writes are always ready and should
// only be issued while no pixel is in flight.
module pixel_motion_and_red_detect_unit #(
  parameter int MAX_FRAME_PIXELS = 1048576
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pmrd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmrd_pkg::DIV_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pmrd_pkg::CH_W-1:0]            in_cur_r,
  input  logic [pmrd_pkg::CH_W-1:0]            in_cur_g,
  input  logic [pmrd_pkg::CH_W-1:0]            in_cur_b,
  input  logic [pmrd_pkg::CH_W-1:0]            in_ref_r,
  input  logic [pmrd_pkg::CH_W-1:0]            in_ref_g,
  input  logic [pmrd_pkg::CH_W-1:0]            in_ref_b,
  input  logic                                 in_last_pixel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pmrd_pkg::HUE_W-1:0]           out_hue,
  output logic [pmrd_pkg::BRIGHT_W-1:0]        out_brightness,
  output logic                                 out_pixel_changed,
  output logic                                 out_red_hit,
  output logic                                 out_frame_done,
  output logic                                 out_motion_detected,
  output logic                                 out_colour_detected
);

  pmrd_pkg::dp_cmd_t  cmd;
  pmrd_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pmrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pmrd_dpath #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cur_r           (in_cur_r),
    .cur_g           (in_cur_g),
    .cur_b           (in_cur_b),
    .ref_r           (in_ref_r),
    .ref_g           (in_ref_g),
    .ref_b           (in_ref_b),
    .last_pixel      (in_last_pixel),
    .hue             (out_hue),
    .brightness      (out_brightness),
    .pixel_changed   (out_pixel_changed),
    .red_hit         (out_red_hit),
    .frame_done      (out_frame_done),
    .motion_detected (out_motion_detected),
    .colour_detected (out_colour_detected)
  );

endmodule

[src/pmrd_hue_div.sv]
module pmrd_hue_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pmrd_pkg::NUM_W-1:0]     num,
  input  logic [pmrd_pkg::CH_W-1:0]      den,
  output logic                           done,
  output logic [pmrd_pkg::HUE_W-1:0]     quot
);

  localparam int QW    = pmrd_pkg::HUE_W;
  localparam int CH    = pmrd_pkg::CH_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CH-1:0]    rem_r;
  logic [QW-1:0]    low_r;
  logic [CH-1:0]    den_r;
  logic [QW-1:0]    quot_r;
  logic [CH:0]      trial;
  logic             take;

  // quotient is below 512, so the top bits of num already sit below den
  assign trial = {rem_r, low_r[QW-1]};
  assign take  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNT_W'(QW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num[pmrd_pkg::NUM_W-1:QW];
      low_r  <= num[QW-1:0];
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= take ? CH'(trial - {1'b0, den_r}) : trial[CH-1:0];
      low_r  <= {low_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], take};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[src/pmrd_dpath.sv]
module pmrd_dpath #(
  parameter int MAX_FRAME_PIXELS = 1048576
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pmrd_pkg::dp_cmd_t                 cmd,
  output pmrd_pkg::dp_stat_t                stat,
  input  logic                              cfg_we,
  input  logic [pmrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmrd_pkg::DIV_W-1:0]        cfg_data,
  input  logic [pmrd_pkg::CH_W-1:0]         cur_r,
  input  logic [pmrd_pkg::CH_W-1:0]         cur_g,
  input  logic [pmrd_pkg::CH_W-1:0]         cur_b,
  input  logic [pmrd_pkg::CH_W-1:0]         ref_r,
  input  logic [pmrd_pkg::CH_W-1:0]         ref_g,
  input  logic [pmrd_pkg::CH_W-1:0]         ref_b,
  input  logic                              last_pixel,
  output logic [pmrd_pkg::HUE_W-1:0]        hue,
  output logic [pmrd_pkg::BRIGHT_W-1:0]     brightness,
  output logic                              pixel_changed,
  output logic                              red_hit,
  output logic                              frame_done,
  output logic                              motion_detected,
  output logic                              colour_detected
);

  localparam int CH   = pmrd_pkg::CH_W;
  localparam int NW   = pmrd_pkg::NUM_W;
  localparam int CW   = pmrd_pkg::CNT_W;
  localparam int DW   = pmrd_pkg::DIV_W;
  localparam int PW   = CW + DW;
  localparam longint CNT_MAX = (longint'(1) << CW) - 1;
  localparam logic [CW-1:0] CNT_CAP =
    (longint'(MAX_FRAME_PIXELS) < CNT_MAX) ? CW'(MAX_FRAME_PIXELS) : {CW{1'b1}};

  // configuration
  logic [CH-1:0] change_range_r;
  logic [DW-1:0] motion_div_r;
  logic [DW-1:0] colour_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_range_r <= pmrd_pkg::CHANGE_RANGE_RST;
      motion_div_r   <= pmrd_pkg::DIVISOR_RST;
      colour_div_r   <= pmrd_pkg::DIVISOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pmrd_pkg::CFG_CHANGE_RANGE:   change_range_r <= cfg_data[CH-1:0];
        pmrd_pkg::CFG_MOTION_DIVISOR: motion_div_r   <= cfg_data;
        pmrd_pkg::CFG_COLOUR_DIVISOR: colour_div_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // hue numerator and denominator, straight from the input ports
  logic [CH-1:0] mx, mn, dlt;
  logic [NW-1:0] d17, num, r17, g17, b17;
  logic [CH-1:0] den;

  always_comb begin
    mx = (cur_r > cur_b) ? cur_r : cur_b;
    if (cur_g > mx) mx = cur_g;
    mn = (cur_r < cur_b) ? cur_r : cur_b;
    if (cur_g < mn) mn = cur_g;
    dlt = mx - mn;
    d17 = NW'(dlt);
    r17 = NW'(cur_r);
    g17 = NW'(cur_g);
    b17 = NW'(cur_b);
    den = dlt;
    if (dlt == '0) begin
      // gray pixel gets hue zero
      num = '0;
      den = CH'(1);
    end else if (mx == cur_r) begin
      if (cur_g >= cur_b) num = pmrd_pkg::DEG_60 * (g17 - b17);
      else num = pmrd_pkg::DEG_360 * d17 - pmrd_pkg::DEG_60 * (b17 - g17);
    end else if (mx == cur_g) begin
      if (cur_b >= cur_r) num = pmrd_pkg::DEG_120 * d17 + pmrd_pkg::DEG_60 * (b17 - r17);
      else num = pmrd_pkg::DEG_120 * d17 - pmrd_pkg::DEG_60 * (r17 - b17);
    end else begin
      if (cur_r >= cur_g) num = pmrd_pkg::DEG_240 * d17 + pmrd_pkg::DEG_60 * (r17 - g17);
      else num = pmrd_pkg::DEG_240 * d17 - pmrd_pkg::DEG_60 * (g17 - r17);
    end
  end

  logic                         div_done;
  logic [pmrd_pkg::HUE_W-1:0]   div_quot;

  pmrd_hue_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.capture),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign stat.div_done = div_done;

  // brightness: floor(x / 255) as (x + 1 + (x >> 8)) >> 8, exact below 65535
  logic [14:0]                   bx;
  logic [15:0]                   bsum;
  logic [pmrd_pkg::BRIGHT_W-1:0] bright;

  assign bx     = 15'(mx) * pmrd_pkg::BRIGHT_SCALE;
  assign bsum   = 16'(bx) + 16'd1 + 16'(bx[14:8]);
  assign bright = bsum[14:8];

  // change test per channel
  function automatic logic far_from(input logic [7:0] c, input logic [7:0] r,
                                    input logic [7:0] rng);
    logic [7:0] diff;
    diff = (c >= r) ? (c - r) : (r - c);
    return (diff >= rng);
  endfunction

  logic changed;
  assign changed = far_from(cur_r, ref_r, change_range_r) |
                   far_from(cur_g, ref_g, change_range_r) |
                   far_from(cur_b, ref_b, change_range_r);

  logic [pmrd_pkg::BRIGHT_W-1:0] bright_r;
  logic                          changed_r;
  logic                          last_r;
  logic                          hit_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bright_r  <= bright;
      changed_r <= changed;
      last_r    <= last_pixel;
    end
  end

  logic hit;
  assign hit = (div_quot >= pmrd_pkg::HUE_RED_MIN) &&
               (bright_r >= pmrd_pkg::BRIGHT_RED_MIN);

  // frame counters
  logic [CW-1:0] pix_r, pix_nxt;
  logic [CW-1:0] chg_r, chg_nxt;
  logic [CW-1:0] hcnt_r, hcnt_nxt;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (c < CNT_CAP) ? (c + 1'b1) : CNT_CAP;
  endfunction

  always_comb begin
    pix_nxt  = pix_r;
    chg_nxt  = chg_r;
    hcnt_nxt = hcnt_r;
    if (cmd.upd) begin
      pix_nxt = sat_inc(pix_r);
      if (changed_r) chg_nxt = sat_inc(chg_r);
      if (hit) hcnt_nxt = sat_inc(hcnt_r);
    end else if (cmd.fin && last_r) begin
      pix_nxt  = '0;
      chg_nxt  = '0;
      hcnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r  <= '0;
      chg_r  <= '0;
      hcnt_r <= '0;
    end else begin
      pix_r  <= pix_nxt;
      chg_r  <= chg_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) hit_r <= hit;
  end

  // count > floor(pix / div) holds exactly when count * div > pix
  logic [DW-1:0] md_eff, cd_eff;
  logic [PW-1:0] prod_m_r, prod_c_r;

  assign md_eff = (motion_div_r == '0) ? DW'(1) : motion_div_r;
  assign cd_eff = (colour_div_r == '0) ? DW'(1) : colour_div_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_m_r <= PW'(chg_r) * PW'(md_eff);
      prod_c_r <= PW'(hcnt_r) * PW'(cd_eff);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      hue             <= div_quot;
      brightness      <= bright_r;
      pixel_changed   <= changed_r;
      red_hit         <= hit_r;
      frame_done      <= last_r;
      motion_detected <= last_r && (prod_m_r > PW'(pix_r));
      colour_detected <= last_r && (prod_c_r > PW'(pix_r));
    end
  end

endmodule

[src/pmrd_ctrl.sv]
module pmrd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pmrd_pkg::dp_cmd_t   cmd,
  input  pmrd_pkg::dp_stat_t  stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.upd     = 1'b0;
    cmd.mul     = 1'b0;
    cmd.fin     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold here until the previous result has been taken
        if (slot_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/pmrd_checker.sv]
module pmrd_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [pmrd_pkg::HUE_W-1:0]     out_hue,
  input  logic [pmrd_pkg::BRIGHT_W-1:0]  out_brightness,
  input  logic                           out_pixel_changed,
  input  logic                           out_red_hit,
  input  logic                           out_frame_done,
  input  logic                           out_motion_detected,
  input  logic                           out_colour_detected
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hue) &&
      $stable(out_brightness) && $stable(out_pixel_changed) && $stable(out_red_hit) &&
      $stable(out_frame_done) && $stable(out_motion_detected) &&
      $stable(out_colour_detected))
    else $error("result changed while stalled");

  // one pixel at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  a_decision_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> !out_motion_detected && !out_colour_detected)
    else $error("frame decision outside last pixel");

  a_red_hit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red_hit == ((out_hue >= pmrd_pkg::HUE_RED_MIN) &&
                                  (out_brightness >= pmrd_pkg::BRIGHT_RED_MIN)))
    else $error("red hit disagrees with hue and brightness");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue <= 9'd359) && (out_brightness <= 7'd100))
    else $error("hue or brightness out of range");

endmodule

bind pixel_motion_and_red_detect_unit pmrd_checker u_pmrd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_hue             (out_hue),
  .out_brightness      (out_brightness),
  .out_pixel_changed   (out_pixel_changed),
  .out_red_hit         (out_red_hit),
  .out_frame_done      (out_frame_done),
  .out_motion_detected (out_motion_detected),
  .out_colour_detected (out_colour_detected)
);

[tb/pixel_motion_and_red_detect_unit_tb.sv]
`timescale 1ns / 1ps

module pixel_motion_and_red_detect_unit_tb;

  localparam int CH_W      = pmrd_pkg::CH_W;
  localparam int HUE_W     = pmrd_pkg::HUE_W;
  localparam int BRIGHT_W  = pmrd_pkg::BRIGHT_W;
  localparam int DIV_W     = pmrd_pkg::DIV_W;
  localparam int CFG_IDX_W = pmrd_pkg::CFG_IDX_W;

  // small frame cap so counter saturation is reachable in a short run
  localparam int FRAME_PIXEL_CAP = 100;
  localparam int CNT_MAX         = 2097151;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int SECTION_PIXELS  = 190;
  localparam int HOLD_AT         = 350;
  localparam int HOLD_CYCLES     = 250;
  localparam int DRAIN_SLACK     = 40;
  localparam int IDLE_PCT        = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] cur_r;
    logic [CH_W-1:0] cur_g;
    logic [CH_W-1:0] cur_b;
    logic [CH_W-1:0] ref_r;
    logic [CH_W-1:0] ref_g;
    logic [CH_W-1:0] ref_b;
    logic            last_px;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]    hue;
    logic [BRIGHT_W-1:0] brightness;
    logic                pixel_changed;
    logic                red_hit;
    logic                frame_done;
    logic                motion;
    logic                colour;
  } result_t;

  class red_motion_scoreboard;
    logic [CH_W-1:0]  change_range;
    logic [DIV_W-1:0] motion_div;
    logic [DIV_W-1:0] colour_div;
    int unsigned      frame_pixels;
    int unsigned      frame_changed;
    int unsigned      frame_hits;
    int unsigned      cap;
    result_t          expected_q[$];
    int               errors;

    function new(int unsigned frame_cap);
      cap           = (frame_cap < CNT_MAX) ? frame_cap : CNT_MAX;
      change_range  = pmrd_pkg::CHANGE_RANGE_RST;
      motion_div    = pmrd_pkg::DIVISOR_RST;
      colour_div    = pmrd_pkg::DIVISOR_RST;
      frame_pixels  = 0;
      frame_changed = 0;
      frame_hits    = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIV_W-1:0] data);
      case (idx)
        pmrd_pkg::CFG_CHANGE_RANGE:   change_range = data[CH_W-1:0];
        pmrd_pkg::CFG_MOTION_DIVISOR: motion_div   = data;
        pmrd_pkg::CFG_COLOUR_DIVISOR: colour_div   = data;
        default: ;
      endcase
    endfunction

    function int unsigned bump(int unsigned c);
      return (c < cap) ? c + 1 : cap;
    endfunction

    function bit beyond(int c, int base, int rng);
      return (c <= base - rng) || (c >= base + rng);
    endfunction

    function logic [HUE_W-1:0] hue_deg(int r, int g, int b);
      int mx, mn, d, num;
      mx = (r > b) ? r : b;
      if (g > mx) mx = g;
      mn = (r < b) ? r : b;
      if (g < mn) mn = g;
      d = mx - mn;
      if (d == 0) return '0;
      // red sector wraps around 360 when blue leads green
      if (mx == r) begin
        num = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
      end else if (mx == g) begin
        num = 120 * d + 60 * (b - r);
      end else begin
        num = 240 * d + 60 * (r - g);
      end
      return HUE_W'(num / d);
    endfunction

    function void note_pixel(pixel_t p);
      result_t     e;
      int          mx;
      int unsigned md, cd;
      mx = (p.cur_r > p.cur_b) ? p.cur_r : p.cur_b;
      if (p.cur_g > mx) mx = p.cur_g;
      e.hue           = hue_deg(p.cur_r, p.cur_g, p.cur_b);
      e.brightness    = BRIGHT_W'((mx * 100) / 255);
      e.pixel_changed = beyond(p.cur_r, p.ref_r, change_range) ||
                        beyond(p.cur_g, p.ref_g, change_range) ||
                        beyond(p.cur_b, p.ref_b, change_range);
      e.red_hit       = (e.hue >= pmrd_pkg::HUE_RED_MIN) &&
                        (e.brightness >= pmrd_pkg::BRIGHT_RED_MIN);
      e.frame_done    = p.last_px;
      e.motion        = 1'b0;
      e.colour        = 1'b0;
      frame_pixels = bump(frame_pixels);
      if (e.pixel_changed) frame_changed = bump(frame_changed);
      if (e.red_hit) frame_hits = bump(frame_hits);
      if (p.last_px) begin
        md = (motion_div == 0) ? 1 : motion_div;
        cd = (colour_div == 0) ? 1 : colour_div;
        e.motion      = frame_changed > frame_pixels / md;
        e.colour      = frame_hits > frame_pixels / cd;
        frame_pixels  = 0;
        frame_changed = 0;
        frame_hits    = 0;
      end
      expected_q.push_back(e);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      check_field("hue", e.hue, got.hue);
      check_field("brightness", e.brightness, got.brightness);
      check_field("pixel_changed", e.pixel_changed, got.pixel_changed);
      check_field("red_hit", e.red_hit, got.red_hit);
      check_field("frame_done", e.frame_done, got.frame_done);
      check_field("motion_detected", e.motion, got.motion);
      check_field("colour_detected", e.colour, got.colour);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIV_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [CH_W-1:0]      in_cur_r, in_cur_g, in_cur_b;
  logic [CH_W-1:0]      in_ref_r, in_ref_g, in_ref_b;
  logic                 in_last_pixel;
  logic                 out_valid;
  logic                 out_ready;
  logic [HUE_W-1:0]     out_hue;
  logic [BRIGHT_W-1:0]  out_brightness;
  logic                 out_pixel_changed;
  logic                 out_red_hit;
  logic                 out_frame_done;
  logic                 out_motion_detected;
  logic                 out_colour_detected;

  red_motion_scoreboard sb;
  bit                   no_idle = 1'b0;
  int                   results_taken = 0;
  int                   cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pixel_motion_and_red_detect_unit #(
    .MAX_FRAME_PIXELS(FRAME_PIXEL_CAP)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cur_r            (in_cur_r),
    .in_cur_g            (in_cur_g),
    .in_cur_b            (in_cur_b),
    .in_ref_r            (in_ref_r),
    .in_ref_g            (in_ref_g),
    .in_ref_b            (in_ref_b),
    .in_last_pixel       (in_last_pixel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hue             (out_hue),
    .out_brightness      (out_brightness),
    .out_pixel_changed   (out_pixel_changed),
    .out_red_hit         (out_red_hit),
    .out_frame_done      (out_frame_done),
    .out_motion_detected (out_motion_detected),
    .out_colour_detected (out_colour_detected)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.hue           = out_hue;
      got.brightness    = out_brightness;
      got.pixel_changed = out_pixel_changed;
      got.red_hit       = out_red_hit;
      got.frame_done    = out_frame_done;
      got.motion        = out_motion_detected;
      got.colour        = out_colour_detected;
      sb.check_result(got);
      results_taken++;
    end
  end

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin : result_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_taken >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic int clamp8(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  function automatic pixel_t mk_pixel(int cr, int cg, int cb, int rr, int rg, int rb,
                                      bit lp);
    pixel_t p;
    p.cur_r   = CH_W'(cr);
    p.cur_g   = CH_W'(cg);
    p.cur_b   = CH_W'(cb);
    p.ref_r   = CH_W'(rr);
    p.ref_g   = CH_W'(rg);
    p.ref_b   = CH_W'(rb);
    p.last_px = lp;
    return p;
  endfunction

  function automatic pixel_t random_pixel(int p_change, int p_red);
    int c[3];
    int rf[3];
    int rng, sgn;
    bit moving;
    rng = sb.change_range;
    if ($urandom_range(0, 99) < p_red) begin
      // bright red leaning toward magenta, straddles the 340 degree edge
      c[0] = $urandom_range(160, 255);
      c[1] = $urandom_range(0, c[0] / 3);
      c[2] = c[1] + int'($urandom_range(0, (c[0] - c[1]) / 2));
    end else if ($urandom_range(0, 7) == 0) begin
      c[0] = $urandom_range(0, 255);
      c[1] = c[0];
      c[2] = c[0];
    end else begin
      for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 255);
    end
    moving = $urandom_range(0, 99) < p_change;
    for (int i = 0; i < 3; i++) begin
      sgn = $urandom_range(0, 1) ? 1 : -1;
      if (moving) begin
        case ($urandom_range(0, 2))
          0:       rf[i] = $urandom_range(0, 255);
          1:       rf[i] = clamp8(c[i] + sgn * (rng - 1 + int'($urandom_range(0, 2))));
          default: rf[i] = c[i];
        endcase
      end else if (rng > 0) begin
        rf[i] = clamp8(c[i] + int'($urandom_range(0, 2 * (rng - 1))) - (rng - 1));
      end else begin
        rf[i] = c[i];
      end
    end
    return mk_pixel(c[0], c[1], c[2], rf[0], rf[1], rf[2], 1'b0);
  endfunction

  task automatic send_pixel(input pixel_t p);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cur_r      <= p.cur_r;
    in_cur_g      <= p.cur_g;
    in_cur_b      <= p.cur_b;
    in_ref_r      <= p.ref_r;
    in_ref_g      <= p.ref_g;
    in_ref_b      <= p.ref_b;
    in_last_pixel <= p.last_px;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input int p_change, input int p_red);
    pixel_t p;
    for (int k = 0; k < len; k++) begin
      p = random_pixel(p_change, p_red);
      p.last_px = (k == len - 1);
      send_pixel(p);
    end
  endtask

  task automatic run_frames(input int target);
    int sent, len, k;
    sent = 0;
    while (sent < target) begin
      k = $urandom_range(0, 99);
      if (k < 70) len = $urandom_range(1, 12);
      else if (k < 95) len = $urandom_range(13, 60);
      else len = $urandom_range(61, FRAME_PIXEL_CAP - 1);
      send_frame(len, $urandom_range(0, 100), $urandom_range(0, 100));
      sent += len;
    end
  endtask

  // hold the input until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_config(input logic [CH_W-1:0] rng, input logic [DIV_W-1:0] md,
                              input logic [DIV_W-1:0] cd, input bit poke_unused);
    logic [CFG_IDX_W-1:0] idx_list[4];
    logic [DIV_W-1:0]     data_list[4];
    int                   n;
    idx_list[0]  = pmrd_pkg::CFG_CHANGE_RANGE;
    data_list[0] = {8'($urandom_range(0, 255)), rng};
    idx_list[1]  = pmrd_pkg::CFG_MOTION_DIVISOR;
    data_list[1] = md;
    idx_list[2]  = pmrd_pkg::CFG_COLOUR_DIVISOR;
    data_list[2] = cd;
    idx_list[3]  = CFG_UNUSED;
    data_list[3] = DIV_W'($urandom_range(0, 65535));
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= data_list[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx_list[i], data_list[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_cur_r      = '0;
    in_cur_g      = '0;
    in_cur_b      = '0;
    in_ref_r      = '0;
    in_ref_g      = '0;
    in_ref_b      = '0;
    in_last_pixel = 1'b0;
    sb = new(FRAME_PIXEL_CAP);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pixels under the reset settings
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 0));             // gray black
    send_pixel(mk_pixel(255, 255, 255, 255, 255, 255, 0)); // gray white
    send_pixel(mk_pixel(128, 128, 128, 112, 144, 128, 0)); // exactly at range
    send_pixel(mk_pixel(255, 0, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(0, 255, 0, 0, 255, 0, 0));
    send_pixel(mk_pixel(0, 0, 255, 0, 0, 255, 1));
    send_pixel(mk_pixel(255, 255, 0, 240, 255, 0, 0));     // one short of range
    send_pixel(mk_pixel(0, 255, 255, 0, 255, 255, 0));
    send_pixel(mk_pixel(255, 0, 255, 255, 0, 255, 0));
    send_pixel(mk_pixel(255, 0, 85, 255, 0, 85, 0));       // hue lands on 340
    send_pixel(mk_pixel(255, 0, 86, 255, 0, 86, 0));       // hue 339
    send_pixel(mk_pixel(179, 0, 59, 179, 0, 59, 0));       // brightness 70
    send_pixel(mk_pixel(178, 0, 59, 178, 0, 59, 0));       // brightness 69
    send_pixel(mk_pixel(255, 0, 1, 255, 0, 1, 1));         // hue 359
    send_pixel(mk_pixel(0, 255, 255, 255, 0, 0, 1));       // one-pixel frame
    send_pixel(mk_pixel(1, 0, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(10, 20, 30, 26, 4, 46, 0));
    send_pixel(mk_pixel(200, 100, 50, 185, 115, 65, 0));
    send_pixel(mk_pixel(255, 128, 0, 255, 128, 0, 0));
    send_pixel(mk_pixel(0, 128, 255, 0, 128, 255, 0));
    send_pixel(mk_pixel(255, 0, 128, 255, 0, 128, 1));
    send_pixel(mk_pixel(254, 1, 253, 0, 255, 0, 0));
    send_pixel(mk_pixel(0, 0, 0, 255, 255, 255, 1));
    run_frames(SECTION_PIXELS);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: write_config(8'd0, 16'd1, 16'd1, 1'b0);
        1: write_config(8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
        2: write_config(8'd16, 16'd0, 16'd0, 1'b0);
        3: write_config(CH_W'($urandom_range(1, 64)), DIV_W'($urandom_range(1, 8)),
                        DIV_W'($urandom_range(1, 8)), 1'b1);
        4: write_config(8'd1, 16'd2, 16'd3, 1'b0);
        5: write_config(CH_W'($urandom_range(0, 255)), DIV_W'($urandom_range(1, 65535)),
                        DIV_W'($urandom_range(1, 65535)), 1'b0);
        default: write_config(8'd32, 16'd4, 16'd4, 1'b0);
      endcase
      no_idle = (ph == 4);
      // frames longer than the cap drive the counters into saturation
      if (ph == 2 || ph == 5)
        send_frame(FRAME_PIXEL_CAP + int'($urandom_range(1, 40)), 90, 90);
      run_frames(SECTION_PIXELS);
    end

    drain();
    repeat (DRAIN_SLACK) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
src/pmrd_pkg.sv
src/pmrd_hue_div.sv
src/pmrd_dpath.sv
src/pmrd_ctrl.sv
src/pixel_motion_and_red_detect_unit.sv
src/pmrd_checker.sv
tb/pixel_motion_and_red_detect_unit_tb.sv
